### design/dmic_pkg.sv
`timescale 1ns / 1ps
// dmic_pkg: geometry, field widths and shared types of the direct-mapped icache
// used by dmic_store, direct_mapped_icache_unit and dmic_checker; no dependencies

package dmic_pkg;

  localparam int NUM_LINES      = 512;
  localparam int WORDS_PER_LINE = 8;

  localparam int ADDR_W     = 32;
  localparam int WORD_DW    = 32;
  localparam int LINE_W     = $clog2(NUM_LINES);
  localparam int OFS_W      = $clog2(WORDS_PER_LINE);
  localparam int SLOT_W     = LINE_W + OFS_W;
  localparam int DATA_DEPTH = NUM_LINES * WORDS_PER_LINE;
  localparam int OFS_LSB    = 2;
  localparam int LINE_LSB   = OFS_LSB + OFS_W;
  localparam int TAG_LSB    = 12;
  localparam int TAG_W      = ADDR_W - TAG_LSB;
  localparam int MISS_W     = ADDR_W - LINE_LSB;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 64;
  localparam int OUT_PAD_W  = OUT_DATA_W - WORD_DW - MISS_W;

  localparam logic REQ_FETCH = 1'b0;
  localparam logic REQ_FILL  = 1'b1;

  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
  } tag_entry_t;

  typedef struct packed {
    logic              en;
    logic [LINE_W-1:0] line;
    logic [SLOT_W-1:0] slot;
  } rd_req_t;

  typedef struct packed {
    logic               en;
    logic [LINE_W-1:0]  line;
    logic [SLOT_W-1:0]  slot;
    tag_entry_t         entry;
    logic [WORD_DW-1:0] word;
  } wr_req_t;

endpackage

### design/dmic_store.sv
`timescale 1ns / 1ps
// dmic_store: tag/valid memory and word memory of the icache, with the clearing pass
// run after reset; depends on dmic_pkg

module dmic_store
  import dmic_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  rd_req_t            rd,
  input  wr_req_t            wr,
  output tag_entry_t         rd_tag,
  output logic [WORD_DW-1:0] rd_word,
  output logic               busy
);

  tag_entry_t         tag_mem  [NUM_LINES];
  logic [WORD_DW-1:0] word_mem [DATA_DEPTH];

  logic [SLOT_W-1:0]  clr_cnt;
  logic               wr_en;
  logic [LINE_W-1:0]  wr_line;
  logic [SLOT_W-1:0]  wr_slot;
  tag_entry_t         wr_entry;
  logic [WORD_DW-1:0] wr_word;

  // clearing pass sweeps every word, and the tag entry of the same low index
  always_comb begin
    if (busy) begin
      wr_en    = 1'b1;
      wr_slot  = clr_cnt;
      wr_line  = clr_cnt[LINE_W-1:0];
      wr_entry = '0;
      wr_word  = '0;
    end else begin
      wr_en    = wr.en;
      wr_slot  = wr.slot;
      wr_line  = wr.line;
      wr_entry = wr.entry;
      wr_word  = wr.word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_cnt <= '0;
    end else if (busy) begin
      if (clr_cnt == SLOT_W'(DATA_DEPTH - 1)) begin
        busy <= 1'b0;
      end
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tag_mem[wr_line]  <= wr_entry;
      word_mem[wr_slot] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_tag  <= tag_mem[rd.line];
      rd_word <= word_mem[rd.slot];
    end
  end

endmodule

### design/direct_mapped_icache_unit.sv
`timescale 1ns / 1ps
// direct_mapped_icache_unit: top level of the direct-mapped instruction cache
// depends on dmic_pkg and dmic_store
//
// usage
//   input word: s_tuser = request kind (fetch or fill), s_tdata = address then
//   fill data, s_tlast = last fill word of a line (sets tag and valid)
//   a fetch gives one output word: m_tuser = hit, m_tdata = instruction word
//   (zero on a miss) then the line address bits 31:5 (zero on a hit)
//   a fill word writes its word, clears the line's valid bit unless it is the last, and gives no output
// fetch pipeline and throughput
//   a fetch result passes the read stage (synchronous tag and word memory
//   read), then compare and the output register; one word per cycle is
//   accepted while the output drains
//   fill words are written into the memories at the edge that accepts them,
//   so a fetch in the very next cycle already sees them
// reset and stall
//   after rst the tag and word memories are swept, one word per cycle, through
//   all NUM_LINES * WORDS_PER_LINE words (4096); s_tready stays low meanwhile
//   when m_tready is low the result is held, one further fetch waits in the
//   read stage, and then s_tready drops until the output is taken

module direct_mapped_icache_unit
  import dmic_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // address[31:0], fill_data[63:32]
  input  logic                  s_tuser,   // req_type
  input  logic                  s_tlast,   // fill_last
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // instr_word[31:0], miss_line[58:32], zeros
  output logic                  m_tuser    // hit
);

  logic [ADDR_W-1:0]  in_addr;
  logic [WORD_DW-1:0] in_fill;
  logic               in_acc;
  logic               fetch_acc;
  logic               fill_acc;
  logic               busy;

  rd_req_t            rd;
  wr_req_t            wr;
  tag_entry_t         rd_tag;
  logic [WORD_DW-1:0] rd_word;

  logic               s1_valid;
  logic [TAG_W-1:0]   s1_tag;
  logic [MISS_W-1:0]  s1_miss;
  logic               s1_adv;
  logic               s1_hit;

  logic               out_valid;
  logic               out_hit;
  logic [WORD_DW-1:0] out_word;
  logic [MISS_W-1:0]  out_miss;

  assign in_addr = s_tdata[ADDR_W-1:0];
  assign in_fill = s_tdata[ADDR_W +: WORD_DW];

  assign s1_adv    = !out_valid || m_tready;
  assign s_tready  = !busy && (!s1_valid || s1_adv);
  assign in_acc    = s_tvalid && s_tready;
  assign fetch_acc = in_acc && (s_tuser == REQ_FETCH);
  assign fill_acc  = in_acc && (s_tuser == REQ_FILL);

  always_comb begin
    rd.en        = fetch_acc;
    rd.line      = in_addr[LINE_LSB +: LINE_W];
    rd.slot      = in_addr[OFS_LSB +: SLOT_W];
    wr.en        = fill_acc;
    wr.line      = in_addr[LINE_LSB +: LINE_W];
    wr.slot      = in_addr[OFS_LSB +: SLOT_W];
    wr.entry.valid = s_tlast;
    wr.entry.tag   = in_addr[TAG_LSB +: TAG_W];
    wr.word      = in_fill;
  end

  dmic_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd      (rd),
    .wr      (wr),
    .rd_tag  (rd_tag),
    .rd_word (rd_word),
    .busy    (busy)
  );

  // read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= fetch_acc;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fetch_acc) begin
      s1_tag  <= in_addr[TAG_LSB +: TAG_W];
      s1_miss <= in_addr[LINE_LSB +: MISS_W];
    end
  end

  assign s1_hit = rd_tag.valid && (rd_tag.tag == s1_tag);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      out_hit  <= s1_hit;
      out_word <= s1_hit ? rd_word : '0;
      out_miss <= s1_hit ? '0 : s1_miss;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_hit;
  assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_miss, out_word};

endmodule

### design/dmic_checker.sv
`timescale 1ns / 1ps
// dmic_assertions: port-level assertions for direct_mapped_icache_unit, with its bind
// depends on dmic_pkg

module dmic_assertions
  import dmic_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  s_tuser,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tuser
);

  // the clearing pass keeps the input closed right after reset
  a_closed_after_reset: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("input open right after reset");

  // a new result only follows an accepted fetch, through the read stage and output register
  a_result_from_fetch: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready && (s_tuser == REQ_FETCH), 2))
    else $error("result without a matching fetch");

  a_hit_no_miss_line: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[WORD_DW +: MISS_W] == '0))
    else $error("hit carries a miss line");

  a_miss_no_word: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[WORD_DW-1:0] == '0))
    else $error("miss carries an instruction word");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

endmodule

bind direct_mapped_icache_unit dmic_assertions u_dmic_assertions (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
